FILE: src/sbsm_pkg.sv
// Package with the payload types, codes and decode helpers of the serial bank switch mapper.
package sbsm_pkg;

   localparam int ADDR_WIDTH      = 16;
   localparam int DATA_WIDTH      = 8;
   localparam int OFFSET_WIDTH    = 18;
   localparam int PRG_BYTES_WIDTH = 19;
   localparam int CHR_BYTES_WIDTH = 18;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 19;
   localparam int LOADER_WIDTH    = 5;
   localparam int COUNT_WIDTH     = 3;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] REGION_UNMAPPED = 2'd0;
   localparam logic [1:0] REGION_CHR_ROM  = 2'd1;
   localparam logic [1:0] REGION_PRG_RAM  = 2'd2;
   localparam logic [1:0] REGION_PRG_ROM  = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CFG_PRG_ROM_BYTES = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CFG_CHR_ROM_BYTES = 1'd1;

   localparam logic [1:0] SEL_CONTROL  = 2'd0;
   localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
   localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
   localparam logic [1:0] SEL_PRG      = 2'd3;

   localparam logic [1:0] MIRROR_SINGLE_LOWER = 2'd0;
   localparam logic [1:0] MIRROR_SINGLE_UPPER = 2'd1;
   localparam logic [1:0] MIRROR_VERTICAL     = 2'd2;
   localparam logic [1:0] MIRROR_HORIZONTAL   = 2'd3;

   localparam logic [1:0] PRG_LAYOUT_FIX_LOW  = 2'd2;
   localparam logic [1:0] PRG_LAYOUT_FIX_HIGH = 2'd3;
   localparam logic       CHR_LAYOUT_8K       = 1'b0;

   localparam logic [LOADER_WIDTH-1:0] LOADER_EMPTY = 5'h10;
   localparam logic [COUNT_WIDTH-1:0]  LOAD_BITS    = 3'd5;

   localparam logic [PRG_BYTES_WIDTH-1:0] PRG_BYTES_RESET = 19'd262144;
   localparam logic [CHR_BYTES_WIDTH-1:0] CHR_BYTES_RESET = 18'd131072;

   typedef struct packed {
      logic                  operation;
      logic [ADDR_WIDTH-1:0] address;
      logic [DATA_WIDTH-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [1:0]              region;
      logic [OFFSET_WIDTH-1:0] rom_offset;
      logic                    offset_in_range;
      logic [DATA_WIDTH-1:0]   ram_read_data;
      logic [1:0]              mirroring;
      logic                    ram_enabled;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                 mirror_control;
      logic [1:0]                 prg_layout;
      logic                       chr_layout;
      logic [4:0]                 chr_bank_low;
      logic [4:0]                 chr_bank_high;
      logic [3:0]                 prg_page;
      logic                       ram_enable_flag;
      logic [PRG_BYTES_WIDTH-1:0] prg_rom_bytes;
      logic [CHR_BYTES_WIDTH-1:0] chr_rom_bytes;
   } map_state_type;

   function automatic logic [1:0] region_of(input logic [ADDR_WIDTH-1:0] address);
      logic [1:0] region;
      if (address[15]) begin
         region = REGION_PRG_ROM;
      end else if (address[14:13] == 2'b11) begin
         region = REGION_PRG_RAM;
      end else if (address[14:13] == 2'b00) begin
         region = REGION_CHR_ROM;
      end else begin
         region = REGION_UNMAPPED;
      end
      return region;
   endfunction

endpackage

FILE: src/serial_bank_switch_mapper.sv
// Top level of the serial bank switch mapper: input register, decode and result register.
//
// The mapper takes one bus access per clock cycle while req_stall is low. A transfer loads
// the input register, where the program RAM read is also registered; once the result register
// is empty or rsp_stall is low, decode and bank mapping load it and rsp_valid rises.
// Writes take effect as their access leaves the input register; the next access sees them.
// After reset the program RAM is cleared one byte per cycle, with req_stall held high until
// all RAM_BYTES (8192 by default) bytes are clear; configuration writes are taken throughout.
module serial_bank_switch_mapper #(
   parameter int RAM_BYTES = 8192
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sbsm_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sbsm_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sbsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sbsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int RamAddrWidth = $clog2(RAM_BYTES);

   logic                            s1_valid_ff, s1_valid_in;
   sbsm_pkg::req_type               s1_item_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   sbsm_pkg::rsp_type               rsp_ff;
   logic                            s1_fire;
   logic                            req_accept;
   logic                            ram_busy;
   logic                            ram_we;
   logic [sbsm_pkg::DATA_WIDTH-1:0] ram_data;
   sbsm_pkg::map_state_type         state;
   sbsm_pkg::rsp_type               result;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = ram_busy || (s1_valid_ff && !s1_fire);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign ram_we = s1_fire && s1_item_ff.operation == sbsm_pkg::OP_WRITE &&
                   sbsm_pkg::region_of(s1_item_ff.address) == sbsm_pkg::REGION_PRG_RAM &&
                   state.ram_enable_flag;

   sbsm_ram #(
      .RamBytes (RAM_BYTES)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_payload.address[RamAddrWidth-1:0]),
      .wr_en   (ram_we),
      .wr_addr (s1_item_ff.address[RamAddrWidth-1:0]),
      .wr_data (s1_item_ff.write_data),
      .rd_data (ram_data),
      .busy    (ram_busy)
   );

   sbsm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .item      (s1_item_ff),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .state     (state)
   );

   sbsm_decode u_decode (
      .item     (s1_item_ff),
      .state    (state),
      .ram_data (ram_data),
      .result   (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_payload;
      end
      if (s1_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The RAM clearing sweep starts with every reset.
   a_sweep_start: assert property (@(posedge clock) reset |=> ram_busy)
      else $error("RAM clear did not start after reset");

   // No transfer is taken while the RAM is being cleared.
   a_sweep_block: assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> req_stall)
      else $error("request taken during RAM clear");

   // An access leaving the input register always shows up as a result.
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("result lost after decode");

endmodule

FILE: src/sbsm_ram.sv
// Program RAM with registered read, write forwarding and a clearing sweep after reset.
module sbsm_ram #(
   parameter int RamBytes = 8192
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [$clog2(RamBytes)-1:0]        rd_addr,
   input  logic                               wr_en,
   input  logic [$clog2(RamBytes)-1:0]        wr_addr,
   input  logic [sbsm_pkg::DATA_WIDTH-1:0]    wr_data,
   output logic [sbsm_pkg::DATA_WIDTH-1:0]    rd_data,
   output logic                               busy
);

   localparam int AddrWidth = $clog2(RamBytes);

   logic [sbsm_pkg::DATA_WIDTH-1:0] mem [RamBytes];

   logic                            busy_ff, busy_in;
   logic [AddrWidth-1:0]            clear_addr_ff, clear_addr_in;
   logic [sbsm_pkg::DATA_WIDTH-1:0] rd_data_ff;
   logic                            fwd_ff;
   logic [sbsm_pkg::DATA_WIDTH-1:0] fwd_data_ff;
   logic                            port_we;
   logic [AddrWidth-1:0]            port_addr;
   logic [sbsm_pkg::DATA_WIDTH-1:0] port_data;

   always_comb begin
      clear_addr_in = clear_addr_ff;
      busy_in       = busy_ff;
      if (busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == {AddrWidth{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   assign port_we   = busy_ff || wr_en;
   assign port_addr = busy_ff ? clear_addr_ff : wr_addr;
   assign port_data = busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         busy_ff       <= busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (port_we) begin
         mem[port_addr] <= port_data;
      end
   end

   // A write retiring in the same cycle as a read of that byte is passed on directly.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign busy    = busy_ff;

endmodule

FILE: src/sbsm_regs.sv
// Serial loader, bank registers and size registers of the mapper.
module sbsm_regs (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    fire,
   input  sbsm_pkg::req_type                       item,
   input  logic                                    csr_write,
   input  logic [sbsm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sbsm_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   output sbsm_pkg::map_state_type                 state
);

   sbsm_pkg::map_state_type               state_ff, state_in;
   logic [sbsm_pkg::LOADER_WIDTH-1:0]     loader_ff, loader_in;
   logic [sbsm_pkg::COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [sbsm_pkg::LOADER_WIDTH-1:0]     shifted;
   logic [sbsm_pkg::COUNT_WIDTH-1:0]      count_inc;

   assign shifted   = {item.write_data[0], loader_ff[sbsm_pkg::LOADER_WIDTH-1:1]};
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      loader_in = loader_ff;
      count_in  = count_ff;
      if (csr_write) begin
         case (csr_index)
            sbsm_pkg::CFG_PRG_ROM_BYTES: begin
               state_in.prg_rom_bytes = csr_data[sbsm_pkg::PRG_BYTES_WIDTH-1:0];
            end
            sbsm_pkg::CFG_CHR_ROM_BYTES: begin
               state_in.chr_rom_bytes = csr_data[sbsm_pkg::CHR_BYTES_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
      if (fire && item.operation == sbsm_pkg::OP_WRITE &&
          sbsm_pkg::region_of(item.address) == sbsm_pkg::REGION_PRG_ROM) begin
         if (item.write_data[7]) begin
            loader_in           = sbsm_pkg::LOADER_EMPTY;
            count_in            = '0;
            state_in.prg_layout = sbsm_pkg::PRG_LAYOUT_FIX_HIGH;
         end else if (count_inc >= sbsm_pkg::LOAD_BITS) begin
            loader_in = sbsm_pkg::LOADER_EMPTY;
            count_in  = '0;
            case (item.address[14:13])
               sbsm_pkg::SEL_CONTROL: begin
                  state_in.mirror_control = shifted[1:0];
                  state_in.prg_layout     = shifted[3:2];
                  state_in.chr_layout     = shifted[4];
               end
               sbsm_pkg::SEL_CHR_LOW: begin
                  state_in.chr_bank_low = shifted;
               end
               sbsm_pkg::SEL_CHR_HIGH: begin
                  state_in.chr_bank_high = shifted;
               end
               default: begin
                  state_in.prg_page        = shifted[3:0];
                  state_in.ram_enable_flag = !shifted[4];
               end
            endcase
         end else begin
            loader_in = shifted;
            count_in  = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mirror_control  <= sbsm_pkg::MIRROR_HORIZONTAL;
         state_ff.prg_layout      <= sbsm_pkg::PRG_LAYOUT_FIX_HIGH;
         state_ff.chr_layout      <= sbsm_pkg::CHR_LAYOUT_8K;
         state_ff.chr_bank_low    <= '0;
         state_ff.chr_bank_high   <= '0;
         state_ff.prg_page        <= '0;
         state_ff.ram_enable_flag <= 1'b1;
         state_ff.prg_rom_bytes   <= sbsm_pkg::PRG_BYTES_RESET;
         state_ff.chr_rom_bytes   <= sbsm_pkg::CHR_BYTES_RESET;
         loader_ff                <= sbsm_pkg::LOADER_EMPTY;
         count_ff                 <= '0;
      end else begin
         state_ff  <= state_in;
         loader_ff <= loader_in;
         count_ff  <= count_in;
      end
   end

   assign state = state_ff;

   // The loader never holds more than four pending bits.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < sbsm_pkg::LOAD_BITS - 1'b1 || count_ff == sbsm_pkg::LOAD_BITS - 1'b1)
      else $error("loader count out of range");

   // A clear write empties the loader on the next cycle.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      fire && item.operation == sbsm_pkg::OP_WRITE && item.address[15] && item.write_data[7]
      |=> count_ff == '0 && loader_ff == sbsm_pkg::LOADER_EMPTY &&
          state_ff.prg_layout == sbsm_pkg::PRG_LAYOUT_FIX_HIGH)
      else $error("loader clear not taken");

   // The fifth bit always commits and empties the loader.
   a_commit: assert property (@(posedge clock) disable iff (reset)
      fire && item.operation == sbsm_pkg::OP_WRITE && item.address[15] &&
      !item.write_data[7] && count_ff == sbsm_pkg::LOAD_BITS - 1'b1
      |=> count_ff == '0)
      else $error("commit did not empty the loader");

endmodule

FILE: src/sbsm_decode.sv
// Address decode and bank mapping for one access.
module sbsm_decode (
   input  sbsm_pkg::req_type                   item,
   input  sbsm_pkg::map_state_type             state,
   input  logic [sbsm_pkg::DATA_WIDTH-1:0]     ram_data,
   output sbsm_pkg::rsp_type                   result
);

   logic [1:0]                           region;
   logic [sbsm_pkg::ADDR_WIDTH-1:0]      addr;
   logic [16:0]                          chr_off;
   logic [4:0]                           units;
   logic [4:0]                           last_bank;
   logic [sbsm_pkg::PRG_BYTES_WIDTH-1:0] prg_off;

   assign addr   = item.address;
   assign region = sbsm_pkg::region_of(addr);
   assign units  = state.prg_rom_bytes[18:14];

   always_comb begin
      last_bank = (units == 5'd0) ? 5'd0 : units - 5'd1;

      if (state.chr_layout == sbsm_pkg::CHR_LAYOUT_8K) begin
         chr_off = {state.chr_bank_low[4:1], addr[12:0]};
      end else if (!addr[12]) begin
         chr_off = {state.chr_bank_low, addr[11:0]};
      end else begin
         chr_off = {state.chr_bank_high, addr[11:0]};
      end

      if (state.prg_layout < sbsm_pkg::PRG_LAYOUT_FIX_LOW) begin
         prg_off = {1'b0, state.prg_page[3:1], addr[14:0]};
      end else if (!addr[14]) begin
         if (state.prg_layout == sbsm_pkg::PRG_LAYOUT_FIX_LOW) begin
            prg_off = {5'd0, addr[13:0]};
         end else begin
            prg_off = {1'b0, state.prg_page, addr[13:0]};
         end
      end else if (state.prg_layout == sbsm_pkg::PRG_LAYOUT_FIX_LOW) begin
         prg_off = {1'b0, state.prg_page, addr[13:0]};
      end else begin
         prg_off = {last_bank, addr[13:0]};
      end

      result.region          = region;
      result.rom_offset      = '0;
      result.offset_in_range = 1'b0;
      result.ram_read_data   = '0;
      result.mirroring       = state.mirror_control;
      result.ram_enabled     = state.ram_enable_flag;

      case (region)
         sbsm_pkg::REGION_CHR_ROM: begin
            result.rom_offset      = {1'b0, chr_off};
            result.offset_in_range = {1'b0, chr_off} < state.chr_rom_bytes;
         end
         sbsm_pkg::REGION_PRG_ROM: begin
            result.rom_offset      = prg_off[sbsm_pkg::OFFSET_WIDTH-1:0];
            result.offset_in_range = prg_off < state.prg_rom_bytes;
         end
         sbsm_pkg::REGION_PRG_RAM: begin
            if (item.operation == sbsm_pkg::OP_READ && state.ram_enable_flag) begin
               result.ram_read_data = ram_data;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: tb/sv/serial_bank_switch_mapper_tb.sv
// Self-checking testbench for the serial bank switch mapper: directed table and random traffic.
module serial_bank_switch_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAM_BYTES   = 8192;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 225;

   typedef struct packed {
      logic              typed;
      sbsm_pkg::req_type access;
      sbsm_pkg::rsp_type typed_rsp;
   } access_row_type;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   logic                                 req_stall;
   sbsm_pkg::req_type                    req_payload = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall   = 1'b0;
   sbsm_pkg::rsp_type                    rsp_payload;
   logic                                 csr_valid   = 1'b0;
   logic                                 csr_ready;
   logic [sbsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [sbsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data    = '0;

   logic [sbsm_pkg::LOADER_WIDTH-1:0]    loader_bits;
   logic [sbsm_pkg::COUNT_WIDTH-1:0]     loader_count;
   logic [1:0]                           mirror_ctl;
   logic [1:0]                           prg_layout_q;
   logic                                 chr_layout_q;
   logic [4:0]                           chr_low;
   logic [4:0]                           chr_high;
   logic [3:0]                           prg_page_q;
   logic                                 ram_en;
   logic [7:0]                           prg_ram [RAM_BYTES];
   logic [sbsm_pkg::PRG_BYTES_WIDTH-1:0] prg_limit;
   logic [sbsm_pkg::CHR_BYTES_WIDTH-1:0] chr_limit;

   sbsm_pkg::rsp_type expected_rsps [$];
   access_row_type    directed_rows [$];
   int                fail_count;
   int                rsp_count;
   int                accesses_sent;
   int                cycle_count;
   int                hold_left;
   bit                hold_done;
   bit                steady;

   serial_bank_switch_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sbsm_pkg::rsp_type predict_access(input sbsm_pkg::req_type access);
      sbsm_pkg::rsp_type result;
      logic [15:0]       a;
      logic [12:0]       ram_index;
      int unsigned       full_offset;
      int unsigned       last_bank;
      a = access.address;
      ram_index = a[12:0];
      full_offset = 0;
      result = '0;
      result.mirroring = mirror_ctl;
      result.ram_enabled = ram_en;
      if (a < 16'h2000) begin
         result.region = sbsm_pkg::REGION_CHR_ROM;
         if (chr_layout_q == sbsm_pkg::CHR_LAYOUT_8K) begin
            full_offset = (chr_low >> 1) * 32'h2000 + a[12:0];
         end else if (a < 16'h1000) begin
            full_offset = chr_low * 32'h1000 + a[11:0];
         end else begin
            full_offset = chr_high * 32'h1000 + a[11:0];
         end
         result.offset_in_range = full_offset < chr_limit;
      end else if (a >= 16'h6000 && a < 16'h8000) begin
         result.region = sbsm_pkg::REGION_PRG_RAM;
         if (access.operation == sbsm_pkg::OP_READ && ram_en) begin
            result.ram_read_data = prg_ram[ram_index];
         end
      end else if (a >= 16'h8000) begin
         result.region = sbsm_pkg::REGION_PRG_ROM;
         last_bank = prg_limit >> 14;
         if (last_bank != 0) begin
            last_bank--;
         end
         if (prg_layout_q < sbsm_pkg::PRG_LAYOUT_FIX_LOW) begin
            full_offset = (prg_page_q >> 1) * 32'h8000 + a[14:0];
         end else if (a < 16'hC000) begin
            if (prg_layout_q == sbsm_pkg::PRG_LAYOUT_FIX_LOW) begin
               full_offset = a[13:0];
            end else begin
               full_offset = prg_page_q * 32'h4000 + a[13:0];
            end
         end else if (prg_layout_q == sbsm_pkg::PRG_LAYOUT_FIX_LOW) begin
            full_offset = prg_page_q * 32'h4000 + a[13:0];
         end else begin
            full_offset = last_bank * 32'h4000 + a[13:0];
         end
         result.offset_in_range = full_offset < prg_limit;
      end else begin
         result.region = sbsm_pkg::REGION_UNMAPPED;
      end
      result.rom_offset = sbsm_pkg::OFFSET_WIDTH'(full_offset);

      if (access.operation == sbsm_pkg::OP_WRITE) begin
         if (result.region == sbsm_pkg::REGION_PRG_RAM) begin
            if (ram_en) begin
               prg_ram[ram_index] = access.write_data;
            end
         end else if (result.region == sbsm_pkg::REGION_PRG_ROM) begin
            if (access.write_data[7]) begin
               loader_bits = sbsm_pkg::LOADER_EMPTY;
               loader_count = '0;
               prg_layout_q = sbsm_pkg::PRG_LAYOUT_FIX_HIGH;
            end else begin
               loader_bits = {access.write_data[0], loader_bits[4:1]};
               loader_count = loader_count + 1'b1;
               if (loader_count >= sbsm_pkg::LOAD_BITS) begin
                  case (a[14:13])
                     sbsm_pkg::SEL_CONTROL: begin
                        mirror_ctl = loader_bits[1:0];
                        prg_layout_q = loader_bits[3:2];
                        chr_layout_q = loader_bits[4];
                     end
                     sbsm_pkg::SEL_CHR_LOW: begin
                        chr_low = loader_bits;
                     end
                     sbsm_pkg::SEL_CHR_HIGH: begin
                        chr_high = loader_bits;
                     end
                     default: begin
                        prg_page_q = loader_bits[3:0];
                        ram_en = !loader_bits[4];
                     end
                  endcase
                  loader_bits = sbsm_pkg::LOADER_EMPTY;
                  loader_count = '0;
               end
            end
         end
      end
      return result;
   endfunction

   function automatic access_row_type row(input logic op, input logic [15:0] addr,
                                          input logic [7:0] data, input logic typed,
                                          input sbsm_pkg::rsp_type typed_rsp);
      access_row_type r;
      r.typed = typed;
      r.access = {op, addr, data};
      r.typed_rsp = typed_rsp;
      return r;
   endfunction

   function automatic logic [15:0] random_address();
      case ($urandom_range(0, 3))
         0:       return {3'b000, 13'($urandom)};
         1:       return {3'b011, 13'($urandom)};
         2:       return {1'b1, 15'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_access(input sbsm_pkg::req_type access, input logic typed,
                              input sbsm_pkg::rsp_type typed_rsp);
      sbsm_pkg::rsp_type predicted;
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= access;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_access(access);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
      accesses_sent++;
   endtask

   task automatic random_burst();
      sbsm_pkg::req_type access;
      logic [1:0]        target;
      int                kind;
      int                count;
      int                i;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         if ($urandom_range(0, 3) == 0) begin
            access = {sbsm_pkg::OP_WRITE, 1'b1, 15'($urandom), 1'b1, 7'($urandom)};
            send_access(access, 1'b0, '0);
         end
         target = 2'($urandom_range(0, 3));
         for (i = 0; i < 5; i++) begin
            access.operation = sbsm_pkg::OP_WRITE;
            access.address = (i == 4) ? {1'b1, target, 13'($urandom)} : {1'b1, 15'($urandom)};
            access.write_data = {1'b0, 7'($urandom)};
            send_access(access, 1'b0, '0);
         end
         count = $urandom_range(1, 5);
         for (i = 0; i < count; i++) begin
            access = {sbsm_pkg::OP_READ, random_address(), 8'($urandom)};
            send_access(access, 1'b0, '0);
         end
      end else if (kind < 70) begin
         count = $urandom_range(2, 8);
         for (i = 0; i < count; i++) begin
            access.operation = 1'($urandom);
            access.address = {3'b011, ($urandom_range(0, 1) ? 13'($urandom_range(0, 31))
                                                            : 13'($urandom))};
            access.write_data = 8'($urandom);
            send_access(access, 1'b0, '0);
         end
      end else if (kind < 90) begin
         count = $urandom_range(1, 6);
         for (i = 0; i < count; i++) begin
            access = {sbsm_pkg::OP_READ, random_address(), 8'($urandom)};
            send_access(access, 1'b0, '0);
         end
      end else begin
         count = $urandom_range(1, 4);
         for (i = 0; i < count; i++) begin
            access = 25'($urandom);
            send_access(access, 1'b0, '0);
         end
      end
   endtask

   task automatic program_sizes(input logic [sbsm_pkg::PRG_BYTES_WIDTH-1:0] prg_bytes,
                                input logic [sbsm_pkg::CHR_BYTES_WIDTH-1:0] chr_bytes);
      csr_valid <= 1'b1;
      csr_index <= sbsm_pkg::CFG_PRG_ROM_BYTES;
      csr_data <= prg_bytes;
      do @(posedge clock); while (csr_ready !== 1'b1);
      prg_limit = prg_bytes;
      csr_index <= sbsm_pkg::CFG_CHR_ROM_BYTES;
      csr_data <= {1'b0, chr_bytes};
      do @(posedge clock); while (csr_ready !== 1'b1);
      chr_limit = chr_bytes;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      sbsm_pkg::rsp_type want;
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("result transfer %0d arrived with nothing expected: %h",
                        rsp_count, rsp_payload);
            end
         end else begin
            want = expected_rsps.pop_front();
            if (want.region !== rsp_payload.region ||
                want.rom_offset !== rsp_payload.rom_offset ||
                want.offset_in_range !== rsp_payload.offset_in_range ||
                want.ram_read_data !== rsp_payload.ram_read_data ||
                want.mirroring !== rsp_payload.mirroring ||
                want.ram_enabled !== rsp_payload.ram_enabled) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("result transfer %0d mismatch (region offset in_range ram_data %s",
                           rsp_count, "mirroring ram_enabled)");
                  $display("   expected %0d %h %b %h %0d %b", want.region, want.rom_offset,
                           want.offset_in_range, want.ram_read_data, want.mirroring,
                           want.ram_enabled);
                  $display("   actual   %0d %h %b %h %0d %b", rsp_payload.region,
                           rsp_payload.rom_offset, rsp_payload.offset_in_range,
                           rsp_payload.ram_read_data, rsp_payload.mirroring,
                           rsp_payload.ram_enabled);
               end
            end
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin : result_hold
      if (rsp_count >= HOLD_AT && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 28);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int k;
      for (k = 0; k < RAM_BYTES; k++) begin
         prg_ram[k] = 8'h00;
      end
      loader_bits = sbsm_pkg::LOADER_EMPTY;
      loader_count = '0;
      mirror_ctl = sbsm_pkg::MIRROR_HORIZONTAL;
      prg_layout_q = sbsm_pkg::PRG_LAYOUT_FIX_HIGH;
      chr_layout_q = sbsm_pkg::CHR_LAYOUT_8K;
      chr_low = '0;
      chr_high = '0;
      prg_page_q = '0;
      ram_en = 1'b1;
      prg_limit = sbsm_pkg::PRG_BYTES_RESET;
      chr_limit = sbsm_pkg::CHR_BYTES_RESET;

      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h0000, 8'h00, 1'b1,
         {sbsm_pkg::REGION_CHR_ROM, 18'h00000, 1'b1, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h1FFF, 8'hFF, 1'b1,
         {sbsm_pkg::REGION_CHR_ROM, 18'h01FFF, 1'b1, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h2000, 8'h00, 1'b1,
         {sbsm_pkg::REGION_UNMAPPED, 18'h00000, 1'b0, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h6000, 8'h00, 1'b1,
         {sbsm_pkg::REGION_PRG_RAM, 18'h00000, 1'b0, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h7FFF, 8'hFF, 1'b1,
         {sbsm_pkg::REGION_PRG_RAM, 18'h00000, 1'b0, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h7FFF, 8'h00, 1'b1,
         {sbsm_pkg::REGION_PRG_RAM, 18'h00000, 1'b0, 8'hFF, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h8000, 8'h00, 1'b1,
         {sbsm_pkg::REGION_PRG_ROM, 18'h00000, 1'b1, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'hFFFF, 8'h00, 1'b1,
         {sbsm_pkg::REGION_PRG_ROM, 18'h3FFFF, 1'b1, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h8000, 8'h80, 1'b1,
         {sbsm_pkg::REGION_PRG_ROM, 18'h00000, 1'b1, 8'h00, sbsm_pkg::MIRROR_HORIZONTAL, 1'b1}));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hC123, 8'h7E, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h8001, 8'h01, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hF000, 8'h00, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hA000, 8'h40, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h9FFF, 8'h41, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h8000, 8'h01, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h8000, 8'h03, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h8000, 8'h7F, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'h8000, 8'h11, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hBFFF, 8'h01, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hE000, 8'h01, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hE000, 8'h21, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hE000, 8'h01, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hE000, 8'h05, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_WRITE, 16'hFFFF, 8'h01, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h1000, 8'h00, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'h7FFF, 8'h00, 1'b0, '0));
      directed_rows.push_back(row(sbsm_pkg::OP_READ, 16'hC000, 8'h00, 1'b0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < directed_rows.size(); k++) begin
         send_access(directed_rows[k].access, directed_rows[k].typed, directed_rows[k].typed_rsp);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: program_sizes(19'd16384, 18'd0);
            1: program_sizes(sbsm_pkg::PRG_BYTES_RESET, sbsm_pkg::CHR_BYTES_RESET);
            2: program_sizes(19'(16384 * $urandom_range(1, 16)), 18'($urandom_range(0, 131072)));
            3: program_sizes(19'd32768, 18'(8192 * $urandom_range(0, 16)));
            4: program_sizes(19'($urandom_range(16384, 262144)), 18'($urandom_range(0, 131072)));
            default: program_sizes(19'd131072, 18'd65536);
         endcase
         steady = (phase == 2);
         while (accesses_sent < directed_rows.size() + (phase + 1) * PHASE_ITEMS) begin
            random_burst();
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/sbsm_pkg.sv
src/sbsm_ram.sv
src/sbsm_regs.sv
src/sbsm_decode.sv
src/serial_bank_switch_mapper.sv
tb/sv/serial_bank_switch_mapper_tb.sv
